### rtl/core/sea_ice_cell_shader_assert.svh
// Assertion macros shared by the sea ice cell shader.
`ifndef SEA_ICE_CELL_SHADER_ASSERT_SVH
`define SEA_ICE_CELL_SHADER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SICS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sea ice cell shader: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SICS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sea ice cell shader: next-cycle check failed");

`endif

### rtl/core/sics_pkg.sv
package sics_pkg;

   // Input word: one grid cell.
   typedef struct packed {
      logic [11:0]        cell_x;
      logic [11:0]        cell_y;
      logic [16:0]        sea_value;
      logic signed [23:0] sea_depth;
   } req_word_type;

   // Result word: one shaded cell.
   typedef struct packed {
      logic [16:0] ice_concentration;
      logic [12:0] ice_thickness;
      logic [16:0] lead_fraction;
   } rsp_word_type;

   // Register port geometry.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = 3;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_AIR_TEMPERATURE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FREEZE_TEMPERATURE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSITION_WIDTH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_THICKNESS      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COASTAL_ANCHORING  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BREAKUP            = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_COVERAGE           = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOISE_SEED         = 3'd7;

   // Register reset values.
   localparam logic signed [15:0] AIR_TEMPERATURE_RST    = -16'sd2048;
   localparam logic signed [12:0] FREEZE_TEMPERATURE_RST = -13'sd461;
   localparam logic [12:0]        TRANSITION_WIDTH_RST   = 13'd1280;
   localparam logic [12:0]        MAX_THICKNESS_RST      = 13'd384;
   localparam logic [16:0]        COASTAL_ANCHORING_RST  = 17'd22938;
   localparam logic [16:0]        BREAKUP_RST            = 17'd22938;
   localparam logic [16:0]        COVERAGE_RST           = 17'd52429;
   localparam logic [19:0]        NOISE_SEED_RST         = 20'd1337;

   // Fixed-point constants.
   localparam logic [16:0]        ONE_Q16       = 17'd65536;
   localparam logic [16:0]        SEA_THRESHOLD = 17'd32768;
   localparam logic signed [23:0] DEPTH_80M     = 24'sd20480;
   localparam logic [14:0]        DEPTH_80M_U   = 15'd20480;
   localparam logic [12:0]        MIN_TW        = 13'd26;
   localparam logic [16:0]        MIN_BREAKUP   = 17'd66;
   localparam logic [12:0]        MAX_THICK     = 13'd5120;

   // Coordinate hash multipliers.
   localparam logic [31:0] HASH_X_MUL    = 32'd374761393;
   localparam logic [31:0] HASH_Y_MUL    = 32'd668265263;
   localparam logic [31:0] HASH_SEED_MUL = 32'd2246822519;
   localparam logic [31:0] HASH_MIX_MUL  = 32'd1274126177;

   // Division by five through a reciprocal, exact below 2^22.
   localparam logic [19:0] DIV5_RECIP = 20'd838861;

   // Grid wrap of the coordinates, done by a reciprocal multiply.
   localparam int GRID_SIZE  = 4096;
   localparam int GRID_SHIFT = 29;
   localparam longint GRID_RECIP_L =
      ((longint'(1) << GRID_SHIFT) + longint'(GRID_SIZE) - 1) / longint'(GRID_SIZE);
   localparam logic [GRID_SHIFT-1:0] GRID_RECIP = GRID_SHIFT'(GRID_RECIP_L);
   localparam logic [GRID_SHIFT-1:0] GRID_SIZE_Q = GRID_SHIFT'(GRID_SIZE);

endpackage

### rtl/core/sea_ice_cell_shader.sv
// Throughput: one word per cycle; the pipeline takes a new word whenever a stage is free.
// Depth is set by the 16-bit lead fraction divider, two quotient bits per stage.
// Synchronous reset clears all stage valid bits and loads the register reset values.
// There is no clearing pass; req_ready is high in the cycle after reset.
`include "sea_ice_cell_shader_assert.svh"

module sea_ice_cell_shader import sics_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // Pipeline geometry.
   localparam int DIV_STAGES = 8;
   localparam int DIV_STEPS  = 2;
   localparam int QUO_W      = DIV_STAGES * DIV_STEPS;
   localparam int ST_DIV0    = 4;
   localparam int ST_CONC1   = ST_DIV0 + DIV_STAGES + 1;
   localparam int ST_CONC2   = ST_CONC1 + 1;
   localparam int ST_CONC3   = ST_CONC2 + 1;
   localparam int ST_OUT     = ST_CONC3 + 1;
   localparam int NSTG       = ST_OUT + 1;

   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
      logic [11:0] qx;
      logic [11:0] qy;
      logic        sea;
      logic [16:0] anchor;
   } s1_type;

   typedef struct packed {
      logic [11:0] rx;
      logic [11:0] ry;
      logic        sea;
      logic [33:0] anch_prod;
   } s2_type;

   typedef struct packed {
      logic [31:0] hx;
      logic [31:0] hy;
      logic        sea;
      logic [14:0] fq;
   } s3_type;

   typedef struct packed {
      logic [31:0] mix;
      logic        sea;
      logic [16:0] factor;
   } s4_type;

   typedef struct packed {
      logic [39:0]      rem;
      logic [QUO_W-1:0] quo;
      logic [12:0]      crem;
      logic [QUO_W-1:0] cquo;
      logic             lzero;
      logic             lsat;
      logic             czero;
      logic             csat;
      logic             sea;
      logic [16:0]      factor;
   } div_type;

   typedef struct packed {
      logic [16:0] conc;
      logic [16:0] lead;
      logic [16:0] factor;
      logic        sea;
   } c1_type;

   typedef struct packed {
      logic [16:0] conc;
      logic [16:0] lead;
      logic        sea;
   } c2_type;

   // Configuration registers.
   logic signed [15:0] air_temp_ff, air_temp_in;
   logic signed [12:0] freeze_temp_ff, freeze_temp_in;
   logic [12:0]        trans_width_ff, trans_width_in;
   logic [12:0]        max_thick_ff, max_thick_in;
   logic [16:0]        coast_anch_ff, coast_anch_in;
   logic [16:0]        breakup_ff, breakup_in;
   logic [16:0]        coverage_ff, coverage_in;
   logic [19:0]        noise_seed_ff, noise_seed_in;

   // Values derived from the configuration, registered from it in the following cycle.
   logic [12:0] tw_ff, tw_in;
   logic [16:0] ca_ff, ca_in;
   logic [16:0] cov_ff, cov_in;
   logic [12:0] mt_ff, mt_in;
   logic [39:0] lead_off_ff, lead_off_in;
   logic [39:0] lead_div_ff, lead_div_in;
   logic [31:0] seed_mul_ff, seed_mul_in;

   // Pipeline control.
   logic [NSTG-1:0] vld_ff, vld_in;
   logic [NSTG-1:0] free;

   // Pipeline payload.
   s1_type       s1_ff, s1_in;
   s2_type       s2_ff, s2_in;
   s3_type       s3_ff, s3_in;
   s4_type       s4_ff, s4_in;
   div_type      div_ff [DIV_STAGES+1];
   div_type      div0_in;
   div_type      div_in [DIV_STAGES];
   c1_type       c1_ff, c1_in;
   c2_type       c2_ff, c2_in;
   c2_type       c3_ff, c3_in;
   rsp_word_type out_ff, out_in;

   logic                   csr_wr;
   logic [CSR_INDEX_W-1:0] csr_idx;

   // Register port: writes on the access phase, reads combinationally.
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      air_temp_in    = air_temp_ff;
      freeze_temp_in = freeze_temp_ff;
      trans_width_in = trans_width_ff;
      max_thick_in   = max_thick_ff;
      coast_anch_in  = coast_anch_ff;
      breakup_in     = breakup_ff;
      coverage_in    = coverage_ff;
      noise_seed_in  = noise_seed_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            CSR_AIR_TEMPERATURE:    air_temp_in    = pwdata[15:0];
            CSR_FREEZE_TEMPERATURE: freeze_temp_in = pwdata[12:0];
            CSR_TRANSITION_WIDTH:   trans_width_in = pwdata[12:0];
            CSR_MAX_THICKNESS:      max_thick_in   = pwdata[12:0];
            CSR_COASTAL_ANCHORING:  coast_anch_in  = pwdata[16:0];
            CSR_BREAKUP:            breakup_in     = pwdata[16:0];
            CSR_COVERAGE:           coverage_in    = pwdata[16:0];
            CSR_NOISE_SEED:         noise_seed_in  = pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_AIR_TEMPERATURE:    prdata = {{16{air_temp_ff[15]}}, air_temp_ff};
         CSR_FREEZE_TEMPERATURE: prdata = {{19{freeze_temp_ff[12]}}, freeze_temp_ff};
         CSR_TRANSITION_WIDTH:   prdata = {19'h0, trans_width_ff};
         CSR_MAX_THICKNESS:      prdata = {19'h0, max_thick_ff};
         CSR_COASTAL_ANCHORING:  prdata = {15'h0, coast_anch_ff};
         CSR_BREAKUP:            prdata = {15'h0, breakup_ff};
         CSR_COVERAGE:           prdata = {15'h0, coverage_ff};
         CSR_NOISE_SEED:         prdata = {12'h0, noise_seed_ff};
         default:                prdata = '0;
      endcase
   end

   // Saturated register values and the fixed parts of the lead fraction division.
   always_comb begin : derive_cfg
      logic [16:0] br;
      logic [16:0] bd;
      logic [16:0] open_w;
      logic [40:0] off_full;
      logic [40:0] div_full;
      tw_in  = (trans_width_ff < MIN_TW) ? MIN_TW : trans_width_ff;
      ca_in  = (coast_anch_ff > ONE_Q16) ? ONE_Q16 : coast_anch_ff;
      cov_in = (coverage_ff > ONE_Q16) ? ONE_Q16 : coverage_ff;
      mt_in  = (max_thick_ff > MAX_THICK) ? MAX_THICK : max_thick_ff;
      br     = (breakup_ff > ONE_Q16) ? ONE_Q16 : breakup_ff;
      bd     = (br < MIN_BREAKUP) ? MIN_BREAKUP : br;
      open_w = ONE_Q16 - br;
      // Multiplying by 2^24 - 1 is a shift and a subtract.
      off_full    = {open_w, 24'h000000} - 41'(open_w);
      div_full    = {bd, 24'h000000} - 41'(bd);
      lead_off_in = off_full[39:0];
      lead_div_in = div_full[39:0];
      seed_mul_in = {12'h000, noise_seed_ff} * HASH_SEED_MUL;
   end

   // A stage may load when the output is ready, or when it, or any stage after it, holds a bubble.
   always_comb begin : stage_free
      logic [NSTG-1:0] low_mask;
      for (int k = 0; k < NSTG; k++) begin
         low_mask = (NSTG'(1) << k) - NSTG'(1);
         free[k]  = rsp_ready || !(&(vld_ff | low_mask));
      end
   end

   always_comb begin : stage_valid
      logic [NSTG-1:0] upstream;
      upstream = {vld_ff[NSTG-2:0], req_valid};
      for (int k = 0; k < NSTG; k++) begin
         vld_in[k] = free[k] ? upstream[k] : vld_ff[k];
      end
   end

   assign req_ready = free[0];
   assign rsp_valid = vld_ff[ST_OUT];
   assign rsp_data  = out_ff;

   // Stage 1: grid quotients, sea test and the depth anchor.
   always_comb begin : stage_anchor
      logic [GRID_SHIFT+11:0] px;
      logic [GRID_SHIFT+11:0] py;
      logic [14:0]            u;
      logic [38:0]            pa;
      px = (GRID_SHIFT+12)'(req_data.cell_x) * (GRID_SHIFT+12)'(GRID_RECIP);
      py = (GRID_SHIFT+12)'(req_data.cell_y) * (GRID_SHIFT+12)'(GRID_RECIP);
      if (req_data.sea_depth >= DEPTH_80M) begin
         u = '0;
      end else if (req_data.sea_depth[23]) begin
         u = DEPTH_80M_U;
      end else begin
         u = DEPTH_80M_U - req_data.sea_depth[14:0];
      end
      // anchor = u * 65536 / 20480 = u * 16 / 5.
      pa           = 39'({u, 4'h0}) * 39'(DIV5_RECIP);
      s1_in.x      = req_data.cell_x;
      s1_in.y      = req_data.cell_y;
      s1_in.qx     = px[GRID_SHIFT+11:GRID_SHIFT];
      s1_in.qy     = py[GRID_SHIFT+11:GRID_SHIFT];
      s1_in.sea    = req_data.sea_value > SEA_THRESHOLD;
      s1_in.anchor = pa[38:22];
   end

   // Stage 2: wrapped coordinates and the anchoring weight product.
   always_comb begin : stage_wrap
      logic [GRID_SHIFT-1:0] gx;
      logic [GRID_SHIFT-1:0] gy;
      logic [16:0]           w;
      gx              = GRID_SHIFT'(s1_ff.qx) * GRID_SIZE_Q;
      gy              = GRID_SHIFT'(s1_ff.qy) * GRID_SIZE_Q;
      w               = ONE_Q16 - s1_ff.anchor;
      s2_in.rx        = s1_ff.x - gx[11:0];
      s2_in.ry        = s1_ff.y - gy[11:0];
      s2_in.sea       = s1_ff.sea;
      s2_in.anch_prod = 34'(ca_ff) * 34'(w);
   end

   // Stage 3: coordinate products and the anchoring reduction, 3/10 of the weight.
   always_comb begin : stage_hash
      logic [33:0] x3;
      logic [16:0] y3;
      logic [36:0] pf;
      x3        = s2_ff.anch_prod + {s2_ff.anch_prod[32:0], 1'b0};
      y3        = x3[33:17];
      pf        = 37'(y3) * 37'(DIV5_RECIP);
      s3_in.hx  = {20'h00000, s2_ff.rx} * HASH_X_MUL;
      s3_in.hy  = {20'h00000, s2_ff.ry} * HASH_Y_MUL;
      s3_in.sea = s2_ff.sea;
      s3_in.fq  = pf[36:22];
   end

   // Stage 4: hash sum, first mix and its multiply.
   always_comb begin : stage_mix
      logic [31:0] h;
      logic [31:0] h2;
      h            = s3_ff.hx + s3_ff.hy + seed_mul_ff;
      h2           = h ^ (h >> 13);
      s4_in.mix    = h2 * HASH_MIX_MUL;
      s4_in.sea    = s3_ff.sea;
      s4_in.factor = ONE_Q16 - 17'(s3_ff.fq);
   end

   // Stage 5: noise, lead numerator and coldness numerator, with their saturation tests.
   always_comb begin : stage_setup
      logic [31:0]        mm;
      logic [39:0]        nq;
      logic [39:0]        rr;
      logic signed [17:0] dt;
      mm = s4_ff.mix ^ (s4_ff.mix >> 16);
      nq = {mm[23:0], 16'h0000};
      rr = nq - lead_off_ff;
      dt = {{5{freeze_temp_ff[12]}}, freeze_temp_ff} - {{2{air_temp_ff[15]}}, air_temp_ff};
      div0_in        = '0;
      div0_in.sea    = s4_ff.sea;
      div0_in.factor = s4_ff.factor;
      // Lead fraction: zero below the breakup threshold, full once the quotient reaches one.
      if (nq > lead_off_ff) begin
         if (rr >= lead_div_ff) begin
            div0_in.lsat = 1'b1;
         end else begin
            div0_in.rem = rr;
         end
      end else begin
         div0_in.lzero = 1'b1;
      end
      // Coldness: zero when not below freezing, full when a whole transition width below.
      if (dt <= 18'sd0) begin
         div0_in.czero = 1'b1;
      end else if (dt[16:0] >= {4'h0, tw_ff}) begin
         div0_in.csat = 1'b1;
      end else begin
         div0_in.crem = dt[12:0];
      end
   end

   // Stages 6 to 13: restoring division, two quotient bits per stage for each divider.
   always_comb begin : div_steps
      div_type     d;
      logic [40:0] r2;
      logic [13:0] c2;
      for (int i = 0; i < DIV_STAGES; i++) begin
         d = div_ff[i];
         for (int j = 0; j < DIV_STEPS; j++) begin
            r2 = {d.rem, 1'b0};
            if (r2 >= {1'b0, lead_div_ff}) begin
               r2    = r2 - {1'b0, lead_div_ff};
               d.quo = {d.quo[QUO_W-2:0], 1'b1};
            end else begin
               d.quo = {d.quo[QUO_W-2:0], 1'b0};
            end
            d.rem = r2[39:0];
            c2 = {d.crem, 1'b0};
            if (c2 >= {1'b0, tw_ff}) begin
               c2     = c2 - {1'b0, tw_ff};
               d.cquo = {d.cquo[QUO_W-2:0], 1'b1};
            end else begin
               d.cquo = {d.cquo[QUO_W-2:0], 1'b0};
            end
            d.crem = c2[12:0];
         end
         div_in[i] = d;
      end
   end

   // Stage 14: resolve both quotients and scale coldness by coverage.
   always_comb begin : stage_conc1
      div_type     d;
      logic [16:0] cold;
      logic [33:0] pc;
      d = div_ff[DIV_STAGES];
      if (d.lzero) begin
         c1_in.lead = '0;
      end else if (d.lsat) begin
         c1_in.lead = ONE_Q16;
      end else begin
         c1_in.lead = {1'b0, d.quo};
      end
      if (d.czero) begin
         cold = '0;
      end else if (d.csat) begin
         cold = ONE_Q16;
      end else begin
         cold = {1'b0, d.cquo};
      end
      pc           = 34'(cold) * 34'(cov_ff);
      c1_in.conc   = pc[32:16];
      c1_in.factor = d.factor;
      c1_in.sea    = d.sea;
   end

   // Stage 15: coastal anchoring factor.
   always_comb begin : stage_conc2
      logic [33:0] pc;
      pc         = 34'(c1_ff.conc) * 34'(c1_ff.factor);
      c2_in.conc = pc[32:16];
      c2_in.lead = c1_ff.lead;
      c2_in.sea  = c1_ff.sea;
   end

   // Stage 16: open water removes its share, clamped to one.
   always_comb begin : stage_conc3
      logic [33:0] pc;
      pc = 34'(c2_ff.conc) * 34'(ONE_Q16 - c2_ff.lead);
      if (pc[33:16] > 18'(ONE_Q16)) begin
         c3_in.conc = ONE_Q16;
      end else begin
         c3_in.conc = pc[32:16];
      end
      c3_in.lead = c2_ff.lead;
      c3_in.sea  = c2_ff.sea;
   end

   // Stage 17: thickness and the land-cell zeroing into the output register.
   always_comb begin : stage_out
      logic [29:0] pt;
      pt = 30'(mt_ff) * 30'(c3_ff.conc);
      if (c3_ff.sea) begin
         out_in.ice_concentration = c3_ff.conc;
         out_in.ice_thickness     = pt[28:16];
         out_in.lead_fraction     = c3_ff.lead;
      end else begin
         out_in = '0;
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff         <= '0;
         air_temp_ff    <= AIR_TEMPERATURE_RST;
         freeze_temp_ff <= FREEZE_TEMPERATURE_RST;
         trans_width_ff <= TRANSITION_WIDTH_RST;
         max_thick_ff   <= MAX_THICKNESS_RST;
         coast_anch_ff  <= COASTAL_ANCHORING_RST;
         breakup_ff     <= BREAKUP_RST;
         coverage_ff    <= COVERAGE_RST;
         noise_seed_ff  <= NOISE_SEED_RST;
      end else begin
         vld_ff         <= vld_in;
         air_temp_ff    <= air_temp_in;
         freeze_temp_ff <= freeze_temp_in;
         trans_width_ff <= trans_width_in;
         max_thick_ff   <= max_thick_in;
         coast_anch_ff  <= coast_anch_in;
         breakup_ff     <= breakup_in;
         coverage_ff    <= coverage_in;
         noise_seed_ff  <= noise_seed_in;
      end
   end

   // Derived configuration follows the registers every cycle, reset included.
   always_ff @(posedge clock) begin
      tw_ff       <= tw_in;
      ca_ff       <= ca_in;
      cov_ff      <= cov_in;
      mt_ff       <= mt_in;
      lead_off_ff <= lead_off_in;
      lead_div_ff <= lead_div_in;
      seed_mul_ff <= seed_mul_in;
   end

   // Stage payload registers, each loaded when its stage is free.
   always_ff @(posedge clock) begin
      if (free[0]) begin
         s1_ff <= s1_in;
      end
      if (free[1]) begin
         s2_ff <= s2_in;
      end
      if (free[2]) begin
         s3_ff <= s3_in;
      end
      if (free[3]) begin
         s4_ff <= s4_in;
      end
      if (free[ST_DIV0]) begin
         div_ff[0] <= div0_in;
      end
      for (int i = 0; i < DIV_STAGES; i++) begin
         if (free[ST_DIV0+1+i]) begin
            div_ff[i+1] <= div_in[i];
         end
      end
      if (free[ST_CONC1]) begin
         c1_ff <= c1_in;
      end
      if (free[ST_CONC2]) begin
         c2_ff <= c2_in;
      end
      if (free[ST_CONC3]) begin
         c3_ff <= c3_in;
      end
      if (free[ST_OUT]) begin
         out_ff <= out_in;
      end
   end

   // The input side only stalls when every stage is full and the output is held.
   `SICS_ASSERT_IMPLY(a_ready_low_only_when_full, clock, reset, !req_ready, rsp_valid && !rsp_ready)
   // Complete open water leaves no ice.
   `SICS_ASSERT_IMPLY(a_full_lead_no_ice, clock, reset, rsp_valid && (rsp_data.lead_fraction == ONE_Q16), rsp_data.ice_concentration == '0)
   // Thickness can only come with some concentration.
   `SICS_ASSERT_IMPLY(a_thickness_needs_ice, clock, reset, rsp_valid && (rsp_data.ice_thickness != '0), rsp_data.ice_concentration != '0)
   // Reset empties the pipeline and opens the input side.
   `SICS_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid && req_ready)

endmodule

### sim/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sics_pkg::*;

   typedef longint unsigned u64;

   // Fixed-point constants of the shading arithmetic.
   localparam u64 UNIT          = 65536;
   localparam u64 NOISE_TOP     = 16777215;
   localparam u64 DEPTH_ANCHOR  = 20480;
   localparam u64 TW_FLOOR      = 26;
   localparam u64 BREAKUP_FLOOR = 66;
   localparam u64 THICK_CEIL    = 5120;
   localparam int SEA_LEVEL     = 32768;
   localparam int GRID_CELLS    = 4096;
   localparam int PHASES        = 7;
   localparam int PHASE_CELLS   = 150;
   localparam int TAIL_CYCLES   = 40;
   localparam int STALL_LIMIT   = 5000;

   // Predicts the shaded cell for every accepted word and checks the results in order.
   class shaded_cell_board;
      logic signed [15:0] air_temp;
      logic signed [12:0] freeze_temp;
      logic [12:0]        trans_width;
      logic [12:0]        thick_max;
      logic [16:0]        anchoring;
      logic [16:0]        breakup_frac;
      logic [16:0]        cover_frac;
      logic [19:0]        noise_seed;
      rsp_word_type       awaited_cells[$];
      int unsigned        faults;

      function new();
         air_temp     = AIR_TEMPERATURE_RST;
         freeze_temp  = FREEZE_TEMPERATURE_RST;
         trans_width  = TRANSITION_WIDTH_RST;
         thick_max    = MAX_THICKNESS_RST;
         anchoring    = COASTAL_ANCHORING_RST;
         breakup_frac = BREAKUP_RST;
         cover_frac   = COVERAGE_RST;
         noise_seed   = NOISE_SEED_RST;
         faults       = 0;
      endfunction

      function void load_register(logic [2:0] idx, logic [31:0] value);
         case (idx)
            CSR_AIR_TEMPERATURE:    air_temp     = value[15:0];
            CSR_FREEZE_TEMPERATURE: freeze_temp  = value[12:0];
            CSR_TRANSITION_WIDTH:   trans_width  = value[12:0];
            CSR_MAX_THICKNESS:      thick_max    = value[12:0];
            CSR_COASTAL_ANCHORING:  anchoring    = value[16:0];
            CSR_BREAKUP:            breakup_frac = value[16:0];
            CSR_COVERAGE:           cover_frac   = value[16:0];
            CSR_NOISE_SEED:         noise_seed   = value[19:0];
            default: ;
         endcase
      endfunction

      function rsp_word_type shade(req_word_type c);
         rsp_word_type r;
         bit [31:0]    h;
         longint       depth, dt;
         u64           tw, ca, br, bd, cv, mt, cold, anchor, n, lead, factor, conc, above, full;
         r = '0;
         // Land cells give all zeros.
         if (c.sea_value <= SEA_LEVEL) return r;

         // Registers as they are used: floors and saturation.
         tw = (trans_width < TW_FLOOR) ? TW_FLOOR : u64'(trans_width);
         ca = (anchoring > UNIT) ? UNIT : u64'(anchoring);
         br = (breakup_frac > UNIT) ? UNIT : u64'(breakup_frac);
         cv = (cover_frac > UNIT) ? UNIT : u64'(cover_frac);
         mt = (thick_max > THICK_CEIL) ? THICK_CEIL : u64'(thick_max);
         bd = (br < BREAKUP_FLOOR) ? BREAKUP_FLOOR : br;

         // Coldness factor from the temperature margin.
         dt = longint'(freeze_temp) - longint'(air_temp);
         if (dt <= 0) begin
            cold = 0;
         end else begin
            cold = (u64'(dt) << 16) / tw;
            if (cold > UNIT) cold = UNIT;
         end

         // Coastal anchoring falls linearly to zero at 80 m.
         depth = longint'($signed(c.sea_depth));
         if (depth < 0) depth = 0;
         if (u64'(depth) >= DEPTH_ANCHOR) anchor = 0;
         else anchor = ((DEPTH_ANCHOR - u64'(depth)) << 16) / DEPTH_ANCHOR;

         // Coordinate hash gives 24-bit noise.
         h = 32'(c.cell_x % GRID_CELLS) * 32'd374761393
             + 32'(c.cell_y % GRID_CELLS) * 32'd668265263
             + 32'(noise_seed) * 32'd2246822519;
         h = (h ^ (h >> 13)) * 32'd1274126177;
         h = h ^ (h >> 16);
         n = u64'(h[23:0]);

         // Leads open where the noise rises above one minus breakup.
         above = n * UNIT + br * NOISE_TOP;
         full  = NOISE_TOP * UNIT;
         if (above <= full) begin
            lead = 0;
         end else begin
            lead = ((above - full) << 16) / (NOISE_TOP * bd);
            if (lead > UNIT) lead = UNIT;
         end

         factor = UNIT - (ca * 3 * (UNIT - anchor)) / (10 * UNIT);
         conc = (cold * cv) >> 16;
         conc = (conc * factor) >> 16;
         conc = (conc * (UNIT - lead)) >> 16;
         if (conc > UNIT) conc = UNIT;

         r.ice_concentration = 17'(conc);
         r.ice_thickness     = 13'((mt * conc) >> 16);
         r.lead_fraction     = 17'(lead);
         return r;
      endfunction

      function void note_cell(req_word_type c);
         awaited_cells.push_back(shade(c));
      endfunction

      function void check_cell(rsp_word_type got);
         rsp_word_type want;
         if (awaited_cells.size() == 0) begin
            $error("result word arrived with no cell awaited");
            faults++;
            return;
         end
         want = awaited_cells.pop_front();
         if (got.ice_concentration !== want.ice_concentration) begin
            $error("ice_concentration: expected %0d, actual %0d",
                   want.ice_concentration, got.ice_concentration);
            faults++;
         end
         if (got.ice_thickness !== want.ice_thickness) begin
            $error("ice_thickness: expected %0d, actual %0d",
                   want.ice_thickness, got.ice_thickness);
            faults++;
         end
         if (got.lead_fraction !== want.lead_fraction) begin
            $error("lead_fraction: expected %0d, actual %0d",
                   want.lead_fraction, got.lead_fraction);
            faults++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_word_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_word_type          rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   shaded_cell_board board;
   int                send_idle_pct = 0;
   int                rsp_idle_pct = 0;

   sea_ice_cell_shader dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Result side: check each accepted word, then stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_cell(rsp_data);
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Watchdog: ends the run when nothing moves for too long.
   initial begin
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || psel || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall = 0;
         else stall++;
      end
      $display("testbench failed");
      $finish;
   end

   function automatic req_word_type make_cell(int x, int y, int sea, int depth);
      req_word_type c;
      c.cell_x    = 12'(x);
      c.cell_y    = 12'(y);
      c.sea_value = 17'(sea);
      c.sea_depth = 24'(depth);
      return c;
   endfunction

   // Mostly sea cells, with depths weighted towards the anchoring band.
   function automatic req_word_type random_cell();
      int sea, depth;
      if ($urandom_range(3) != 0) sea = $urandom_range(131071, SEA_LEVEL + 1);
      else sea = $urandom_range(131071);
      case ($urandom_range(3))
         0: depth = $urandom_range(20480);
         1: depth = -int'($urandom_range(4096));
         2: depth = $urandom_range(40000);
         default: depth = $urandom;
      endcase
      return make_cell($urandom_range(4095), $urandom_range(4095), sea, depth);
   endfunction

   // Offers one word after a random gap and waits for it to be taken.
   task automatic send_cell(req_word_type c);
      int gaps;
      gaps = 0;
      while ($urandom_range(99) < send_idle_pct) gaps++;
      if (gaps > 0) begin
         req_valid <= 1'b0;
         repeat (gaps) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= c;
      do @(posedge clock); while (!req_ready);
      board.note_cell(c);
   endtask

   // Holds the input back until every awaited result has come.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.awaited_cells.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      board.load_register(idx, value);
      @(posedge clock);
   endtask

   initial begin
      int vals[8];
      board = new();
      send_idle_pct = 22;
      rsp_idle_pct  = 47;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed cells at the reset settings: field extremes, the sea edge and depth cases.
      send_cell(make_cell(0, 0, 65536, 0));
      send_cell(make_cell(4095, 4095, 131071, 8388607));
      send_cell(make_cell(4095, 0, SEA_LEVEL, 0));
      send_cell(make_cell(0, 4095, SEA_LEVEL + 1, 256));
      send_cell(make_cell(17, 33, 0, -8388608));
      send_cell(make_cell(100, 200, 65536, -1));
      send_cell(make_cell(100, 200, 65536, -8388608));
      send_cell(make_cell(101, 200, 65536, 20479));
      send_cell(make_cell(102, 200, 65536, 20480));
      send_cell(make_cell(103, 200, 65536, 1));
      send_cell(make_cell(2048, 2048, 98304, 10240));
      send_cell(make_cell(1, 2, 131071, -1));
      send_cell(make_cell(2730, 1365, 65536, 5000));
      send_cell(make_cell(1365, 2730, 40000, 12345));
      send_cell(make_cell(4095, 4094, 131071, 0));
      send_cell(make_cell(7, 9, 65535, 30000));

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 3) begin
            send_idle_pct = 47;
            rsp_idle_pct  = 22;
         end else if (phase == 5) begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end

         // New register settings, written only once the block has gone quiet.
         if (phase > 0) begin
            drain();
            case (phase)
               1: begin
                  // Coldest corner: saturating fractions, tiny width, zero breakup.
                  vals[CSR_AIR_TEMPERATURE]    = -32768;
                  vals[CSR_FREEZE_TEMPERATURE] = 4095;
                  vals[CSR_TRANSITION_WIDTH]   = 0;
                  vals[CSR_MAX_THICKNESS]      = 8191;
                  vals[CSR_COASTAL_ANCHORING]  = 131071;
                  vals[CSR_BREAKUP]            = 0;
                  vals[CSR_COVERAGE]           = 131071;
                  vals[CSR_NOISE_SEED]         = 0;
               end
               2: begin
                  // Warmest corner: no coldness, full breakup, all seed bits set.
                  vals[CSR_AIR_TEMPERATURE]    = 32767;
                  vals[CSR_FREEZE_TEMPERATURE] = -4096;
                  vals[CSR_TRANSITION_WIDTH]   = 8191;
                  vals[CSR_MAX_THICKNESS]      = 0;
                  vals[CSR_COASTAL_ANCHORING]  = 0;
                  vals[CSR_BREAKUP]            = 131071;
                  vals[CSR_COVERAGE]           = 0;
                  vals[CSR_NOISE_SEED]         = 1048575;
               end
               5: begin
                  foreach (vals[i]) vals[i] = $urandom;
               end
               6: begin
                  // Ends of the working ranges.
                  vals[CSR_AIR_TEMPERATURE]    = -20480;
                  vals[CSR_FREEZE_TEMPERATURE] = 1280;
                  vals[CSR_TRANSITION_WIDTH]   = 26;
                  vals[CSR_MAX_THICKNESS]      = 5120;
                  vals[CSR_COASTAL_ANCHORING]  = 65536;
                  vals[CSR_BREAKUP]            = 65536;
                  vals[CSR_COVERAGE]           = 65536;
                  vals[CSR_NOISE_SEED]         = 1000000;
               end
               default: begin
                  vals[CSR_AIR_TEMPERATURE]    = int'($urandom_range(25600)) - 20480;
                  vals[CSR_FREEZE_TEMPERATURE] = int'($urandom_range(3840)) - 2560;
                  vals[CSR_TRANSITION_WIDTH]   = $urandom_range(7680, 26);
                  vals[CSR_MAX_THICKNESS]      = $urandom_range(5120);
                  vals[CSR_COASTAL_ANCHORING]  = $urandom_range(65536);
                  vals[CSR_BREAKUP]            = $urandom_range(65536);
                  vals[CSR_COVERAGE]           = $urandom_range(65536);
                  vals[CSR_NOISE_SEED]         = $urandom_range(1000000);
               end
            endcase
            for (int i = 0; i < 8; i++) write_csr(3'(i), 32'(vals[i]));
         end

         for (int k = 0; k < PHASE_CELLS; k++) begin
            send_cell(random_cell());
            // Halfway through one phase the sender waits for the pipeline to empty.
            if (phase == 3 && k == PHASE_CELLS / 2) drain();
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.faults == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
